### hdl/ckhc_pkg.sv
// package for the canonical k-mer hash counter
// holds state encoding, constants and the base decode function
package ckhc_pkg;

    localparam int KMER_MAX = 32;
    localparam int KMER_MIN = 5;
    localparam int DEF_TABLE_DEPTH = 1048576;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_MAX_PROBES = 1024;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODULUS = 2'd2;

    localparam logic OP_INSERT = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_STEP,
        S_FOLD,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_ADV,
        S_DONE,
        S_OUT
    } t_state;

    // 2-bit base code, bit 2 set for a non-base
    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [2:0] r;
        begin
            unique case (c)
                8'h41, 8'h61: r = 3'd0;
                8'h43, 8'h63: r = 3'd1;
                8'h47, 8'h67: r = 3'd2;
                8'h54, 8'h74: r = 3'd3;
                default:      r = 3'd4;
            endcase
            return r;
        end
    endfunction

endpackage

### hdl/canonical_kmer_hash_counter_unit.sv
// An item without a clean k-mer is answered straight from idle; otherwise bit-serial key mod table size,
// key mod step modulus, fold of the step by table size, read/wait/check/advance per probe, then done.
// Throughput: one item at a time, not ready while the shared modulo unit and probe walk run or an output word waits.
// Reset: synchronous active low; a clearing pass clears
// the valid memory, one entry a cycle, before the first item is taken.
// Output word is held in a register until taken.
module canonical_kmer_hash_counter_unit
    import ckhc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int MAX_PROBES  = DEF_MAX_PROBES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // opcode, symbol, read_start, zero pad
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // kmer_ready, kmer_clean, canonical_kmer, slot, hit, occurrences, table_full, pad
    output logic [127:0]          m_axis_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(MAX_PROBES + 1);
    localparam int SW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;

    t_state r_state, n_state;

    logic [5:0]  r_klen;
    logic [20:0] r_tsize, r_smod;
    logic [63:0] r_fwd, r_rev;
    logic [5:0]  r_seen, r_age;
    logic        r_op;
    logic [63:0] r_key;
    logic [63:0] r_shift;
    logic [6:0]  r_bit;
    logic [SW:0] r_rem;
    logic [SW-1:0] r_pos, r_step, r_size, r_smd;
    logic [PW-1:0] r_probe;
    logic [AW-1:0] r_clr;
    logic        r_found, r_empty, r_full;
    logic [COUNT_WIDTH-1:0] r_occ;
    logic        r_ovalid;
    logic [127:0] r_odata;

    // table memories
    logic                   mem_valid [TABLE_DEPTH];
    logic [63:0]            mem_key   [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] mem_cnt   [TABLE_DEPTH];
    logic                   r_rd_valid;
    logic [63:0]            r_rd_key;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;

    logic        in_fire;
    logic [2:0]  code;
    logic [63:0] n_fwd, n_rev;
    logic [5:0]  n_seen, n_age, k_eff;
    logic [63:0] fwd_m, rev_s, key_c;
    logic        rdy, cln;
    logic [SW-1:0] div_sel;
    logic [SW:0] rem_sh;
    logic [SW:0] rem_nx;
    logic [SW:0] pos_sum;
    logic [COUNT_WIDTH-1:0] cmax;

    assign cmax = '1;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    always_comb begin
        logic [63:0] f0, r0;
        logic [5:0]  s0, a0;
        f0 = s_axis_tdata[9] ? 64'd0 : r_fwd;
        r0 = s_axis_tdata[9] ? 64'd0 : r_rev;
        s0 = s_axis_tdata[9] ? 6'd0 : r_seen;
        a0 = s_axis_tdata[9] ? 6'd0 : r_age;
        code = base_code(s_axis_tdata[8:1]);
        if (!code[2]) begin
            n_fwd = {f0[61:0], code[1:0]};
            n_rev = {~code[1:0], r0[63:2]};
            n_age = (a0 < 6'(KMER_MAX)) ? a0 + 6'd1 : a0;
        end else begin
            n_fwd = {f0[61:0], 2'b00};
            n_rev = {2'b11, r0[63:2]};
            n_age = '0;
        end
        n_seen = (s0 < 6'(KMER_MAX)) ? s0 + 6'd1 : s0;
        k_eff = (r_klen < 6'(KMER_MIN)) ? 6'(KMER_MIN)
            : (r_klen > 6'(KMER_MAX)) ? 6'(KMER_MAX) : r_klen;
        rdy = n_seen >= k_eff;
        cln = n_age >= k_eff;
        fwd_m = (k_eff == 6'd0) ? n_fwd : n_fwd & ~(64'hFFFF_FFFF_FFFF_FFFF << {k_eff, 1'b0});
        rev_s = n_rev >> (7'd64 - {k_eff, 1'b0});
        if (k_eff == 6'(KMER_MAX)) begin
            fwd_m = n_fwd;
            rev_s = n_rev;
        end
        key_c = (rev_s <= fwd_m) ? rev_s : fwd_m;
    end

    // restoring modulo, one key bit a cycle
    always_comb begin
        div_sel = (r_state == S_STEP) ? r_smd : r_size;
        rem_sh = {r_rem[SW-1:0], r_shift[63]};
        rem_nx = (rem_sh >= {1'b0, div_sel}) ? rem_sh - {1'b0, div_sel} : rem_sh;
        pos_sum = {1'b0, r_pos} + {1'b0, r_step};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_fire) n_state = (rdy && cln) ? S_MOD : S_IDLE;
            S_MOD:   if (r_bit == 7'd63) n_state = S_STEP;
            S_STEP:  if (r_bit == 7'd63) n_state = S_FOLD;
            S_FOLD:  if (r_bit == 7'd63) n_state = S_READ;
            S_READ:  n_state = S_WAIT;
            S_WAIT:  n_state = S_CHECK;
            S_CHECK: begin
                if (!r_rd_valid || r_rd_key == r_key || r_probe == PW'(MAX_PROBES - 1))
                    n_state = S_DONE;
                else
                    n_state = S_ADV;
            end
            S_ADV:   n_state = S_READ;
            S_DONE:  n_state = S_OUT;
            S_OUT:   if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_klen <= 6'd32;
            r_tsize <= 21'd1048573;
            r_smod <= 21'd524287;
            r_fwd <= '0;
            r_rev <= '0;
            r_seen <= '0;
            r_age <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KMER_LENGTH:  r_klen <= i_cfg_data[5:0];
                    CFG_TABLE_SIZE:   r_tsize <= i_cfg_data;
                    CFG_STEP_MODULUS: r_smod <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (in_fire) begin
                r_fwd <= n_fwd;
                r_rev <= n_rev;
                r_seen <= n_seen;
                r_age <= n_age;
                if (!(rdy && cln)) r_ovalid <= 1'b1;
            end
            if (r_state == S_DONE) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= s_axis_tdata[0];
            r_key <= key_c;
            r_shift <= key_c;
            r_bit <= '0;
            r_rem <= '0;
            r_probe <= '0;
            r_found <= 1'b0;
            r_empty <= 1'b0;
            r_full <= 1'b0;
            r_occ <= '0;
            r_size <= (r_tsize == 21'd0) ? SW'(1)
                : (SW'(r_tsize) > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(r_tsize);
            r_smd <= (r_smod == 21'd0) ? SW'(1) : SW'(r_smod);
            r_odata <= {126'd0, cln, rdy};
        end
        if (r_state == S_MOD || r_state == S_STEP || r_state == S_FOLD) begin
            if (r_bit != 7'd63) begin
                r_shift <= {r_shift[62:0], 1'b0};
                r_rem <= rem_nx;
                r_bit <= r_bit + 7'd1;
            end else begin
                r_rem <= '0;
                if (r_state == S_MOD) begin
                    r_pos <= rem_nx[SW-1:0];
                    r_shift <= r_key;
                    r_bit <= '0;
                end else if (r_state == S_STEP) begin
                    // 1 + key mod smod, reduced by the table size next
                    r_shift <= {rem_nx + (SW+1)'(1), (64-SW-1)'(0)};
                    r_bit <= 7'(63 - SW);
                end else begin
                    r_step <= rem_nx[SW-1:0];
                end
            end
        end
        if (r_state == S_ADV) begin
            r_pos <= (pos_sum >= {1'b0, r_size}) ? SW'(pos_sum - {1'b0, r_size})
                : pos_sum[SW-1:0];
            r_probe <= r_probe + PW'(1);
        end
        if (r_state == S_CHECK) begin
            if (!r_rd_valid) r_empty <= 1'b1;
            else if (r_rd_key == r_key) begin
                r_found <= 1'b1;
                r_occ <= (r_op == OP_INSERT && r_rd_cnt != cmax)
                    ? r_rd_cnt + COUNT_WIDTH'(1) : r_rd_cnt;
            end else if (r_probe == PW'(MAX_PROBES - 1)) r_full <= 1'b1;
            if (!r_rd_valid && r_op == OP_INSERT) r_occ <= COUNT_WIDTH'(1);
        end
        if (r_state == S_DONE) begin
            r_odata[65:2] <= r_key;
            r_odata[85:66] <= 20'(r_pos);
            r_odata[86] <= r_found;
            r_odata[118:87] <= 32'(r_occ);
            r_odata[119] <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) mem_valid[r_clr] <= 1'b0;
        else if (r_state == S_DONE && r_op == OP_INSERT && r_empty)
            mem_valid[r_pos[AW-1:0]] <= 1'b1;
        if (r_state == S_DONE && r_op == OP_INSERT && (r_empty || r_found)) begin
            mem_key[r_pos[AW-1:0]] <= r_key;
            mem_cnt[r_pos[AW-1:0]] <= r_occ;
        end
        if (r_state == S_READ) begin
            r_rd_valid <= mem_valid[r_pos[AW-1:0]];
            r_rd_key <= mem_key[r_pos[AW-1:0]];
            r_rd_cnt <= mem_cnt[r_pos[AW-1:0]];
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accepted while busy");
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> $onehot({r_found, r_empty, r_full}))
        else $error("probe outcome not unique");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_pos < r_size)) else $error("slot out of range");

endmodule

### tb/canonical_kmer_hash_counter_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for canonical_kmer_hash_counter_unit: nucleotide words in,
// expected k-mer keys, probe slots and counts from an internal table predictor
// depends on ckhc_pkg and the unit itself
module canonical_kmer_hash_counter_unit_tb;
    import ckhc_pkg::*;

    localparam int      DEPTH      = DEF_TABLE_DEPTH;
    localparam int      PROBES     = DEF_MAX_PROBES;
    localparam longint  CYCLE_CAP  = 40000000;

    typedef struct packed {
        bit        full;
        bit [31:0] occ;
        bit        hit;
        bit [19:0] slot;
        bit [63:0] kmer;
        bit        clean;
        bit        ready;
    } kmer_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;  // opcode, symbol, read_start, zero pad
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // kmer_ready, kmer_clean, canonical_kmer, slot, hit, occurrences, table_full, pad
    logic [127:0]          m_axis_tdata;

    canonical_kmer_hash_counter_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    bit [5:0]  kmer_len_reg = 6'd32;
    bit [20:0] tsize_reg = 21'd1048573;
    bit [20:0] smod_reg = 21'd524287;
    bit [63:0] fwd_win, rev_win;
    int        seen_cnt, clean_age;
    bit [63:0] key_store[int unsigned];
    bit [31:0] count_store[int unsigned];

    bit [15:0]    pending_words[$];
    kmer_result_t expected_results[$];
    int  send_idle_pct, recv_stall_pct;
    int  err_cnt, words_in, words_out, clean_cnt, hit_cnt, full_cnt;
    longint cycle_cnt;

    task automatic count_kmer(input bit op, input bit [7:0] sym, input bit rs,
                              output kmer_result_t r);
        int k, code;
        bit [63:0] fwd, rev, key;
        longint unsigned tsize, smod, pos, step;
        bit found, empty;
        found = 0;
        empty = 0;
        r = '0;
        if (rs) begin
            fwd_win = '0;
            rev_win = '0;
            seen_cnt = 0;
            clean_age = 0;
        end
        case (sym)
            "A", "a": code = 0;
            "C", "c": code = 1;
            "G", "g": code = 2;
            "T", "t": code = 3;
            default:  code = 4;
        endcase
        if (code < 4) begin
            fwd_win = (fwd_win << 2) | 64'(code);
            rev_win = (rev_win >> 2) | (64'(3 - code) << 62);
            if (clean_age < KMER_MAX) clean_age++;
        end else begin
            fwd_win = fwd_win << 2;
            rev_win = (rev_win >> 2) | (64'd3 << 62);
            clean_age = 0;
        end
        if (seen_cnt < KMER_MAX) seen_cnt++;
        k = kmer_len_reg;
        if (k < KMER_MIN) k = KMER_MIN;
        if (k > KMER_MAX) k = KMER_MAX;
        r.ready = seen_cnt >= k;
        r.clean = clean_age >= k;
        if (!r.ready || !r.clean) return;
        fwd = (k >= 32) ? fwd_win : fwd_win & ((64'd1 << (2 * k)) - 1);
        rev = rev_win >> ((64 - 2 * k) & 63);
        key = (rev <= fwd) ? rev : fwd;
        tsize = tsize_reg;
        if (tsize == 0) tsize = 1;
        if (tsize > DEPTH) tsize = DEPTH;
        smod = (smod_reg == 0) ? 1 : smod_reg;
        pos = key % tsize;
        step = (1 + key % smod) % tsize;
        for (int i = 0; i < PROBES; i++) begin
            if (!key_store.exists(pos)) begin
                empty = 1;
                break;
            end
            if (key_store[pos] == key) begin
                found = 1;
                break;
            end
            if (i + 1 < PROBES) pos = (pos + step) % tsize;
        end
        if (found) begin
            r.hit = 1;
            if (op == OP_INSERT && count_store[pos] != 32'hFFFF_FFFF) count_store[pos]++;
            r.occ = count_store[pos];
        end else if (empty) begin
            if (op == OP_INSERT) begin
                key_store[pos] = key;
                count_store[pos] = 32'd1;
                r.occ = 32'd1;
            end
        end else begin
            r.full = 1;
        end
        r.kmer = key;
        r.slot = pos[19:0];
    endtask

    // driver
    always @(posedge i_clk) begin
        kmer_result_t r;
        bit [15:0] w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                count_kmer(w[0], w[8:1], w[9], r);
                expected_results.push_back(r);
                s_axis_tdata <= w;
                s_axis_tvalid <= 1'b1;
                words_in++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input bit [63:0] e, input bit [63:0] a);
        if (e !== a) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, e, a);
            err_cnt++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        kmer_result_t e, a;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                a = m_axis_tdata[119:0];
                words_out++;
                if (expected_results.size() == 0) begin
                    $error("unexpected output word 0x%0h", m_axis_tdata);
                    err_cnt++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("kmer_ready", e.ready, a.ready);
                    check_field("kmer_clean", e.clean, a.clean);
                    check_field("canonical_kmer", e.kmer, a.kmer);
                    check_field("slot", e.slot, a.slot);
                    check_field("hit", e.hit, a.hit);
                    check_field("occurrences", e.occ, a.occ);
                    check_field("table_full", e.full, a.full);
                    if (e.ready && e.clean) clean_cnt++;
                    if (e.hit) hit_cnt++;
                    if (e.full) full_cnt++;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_word(input bit op, input bit [7:0] sym, input bit rs);
        pending_words.push_back({6'b0, rs, sym, op});
    endtask

    task automatic push_string(input string s, input bit op, input bit rs_first);
        for (int i = 0; i < s.len(); i++) push_word(op, s[i], rs_first && i == 0);
    endtask

    task automatic push_random(input int n);
        string bases;
        bit [7:0] sym;
        bases = "ACGTacgt";
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 6) sym = 8'($urandom_range(255));
            else sym = bases[$urandom_range(7)];
            push_word($urandom_range(99) < 35, sym, $urandom_range(99) < 2);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KMER_LENGTH:  kmer_len_reg = val[5:0];
            CFG_TABLE_SIZE:   tsize_reg = val[20:0];
            CFG_STEP_MODULUS: smod_reg = val[20:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int k, input int tsize, input int smod);
        write_reg(CFG_KMER_LENGTH, k);
        write_reg(CFG_TABLE_SIZE, tsize);
        write_reg(CFG_STEP_MODULUS, smod);
    endtask

    task automatic drain;
        while (pending_words.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        push_random(n);
        drain();
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-A key, both cases, non-bases, lookup, read start mid-run
        configure(5, 1048573, 524287);
        push_string("AAAAA", OP_INSERT, 1);
        push_word(1'b1, "a", 1'b0);
        push_string("CGTcgt", OP_INSERT, 0);
        push_word(OP_INSERT, "N", 1'b0);
        push_word(OP_INSERT, 8'h00, 1'b0);
        push_word(OP_INSERT, 8'hFF, 1'b0);
        push_string("ACGTA", 1'b1, 0);
        push_string("TACGT", OP_INSERT, 1);
        drain();

        configure(32, 1048573, 524287);
        run_phase(250, 0, 0);
        configure(5, 13, 11);
        run_phase(250, 77, 0);
        configure(0, 0, 0);
        run_phase(50, 0, 77);
        configure(63, 21'h1FFFFF, 21'h1FFFFF);
        run_phase(300, 22, 22);
        configure(12, 1009, 997);
        run_phase(400, 0, 0);
        configure(20, 65537, 1048576);
        run_phase(400, 77, 0);
        configure(5, 2, 1);
        run_phase(40, 0, 77);
        configure(7, 101, 3);
        run_phase(150, 22, 22);

        repeat (200) @(posedge i_clk);
        $display("%0d words sent, %0d results checked over nine register settings", words_in,
                 words_out);
        $display("%0d clean k-mers, %0d hits, %0d table-full probes", clean_cnt, hit_cnt,
                 full_cnt);
        if (err_cnt == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ckhc_pkg.sv
hdl/canonical_kmer_hash_counter_unit.sv
tb/canonical_kmer_hash_counter_unit_tb.sv
